// ===== rtl/svap_pkg.sv =====
// Shared types, constants and CORDIC angle table for the view angle projection.
package svap_pkg;

  localparam int Steps = 30;
  localparam logic signed [36:0] NdegPerMdeg = 37'sd1000000;
  localparam logic signed [31:0] InvGainQ30 = 32'sd652032874;
  localparam logic [39:0] SatPos = 40'h7FFFFFFFFF;

  typedef enum logic [1:0] {
    REG_PLANET_RADIUS = 2'd0,
    REG_SAT_RADIUS    = 2'd1,
    REG_SAT_LONGITUDE = 2'd2
  } reg_index_t;

  // Per-step CORDIC angle in nanodegrees.
  function automatic logic signed [37:0] atan_ndeg(input logic [4:0] i);
    logic signed [37:0] a;
    case (i)
      5'd0:  a = 38'sd45000000000;
      5'd1:  a = 38'sd26565051177;
      5'd2:  a = 38'sd14036243468;
      5'd3:  a = 38'sd7125016349;
      5'd4:  a = 38'sd3576334375;
      5'd5:  a = 38'sd1789910608;
      5'd6:  a = 38'sd895173710;
      5'd7:  a = 38'sd447614171;
      5'd8:  a = 38'sd223810500;
      5'd9:  a = 38'sd111905677;
      5'd10: a = 38'sd55952892;
      5'd11: a = 38'sd27976453;
      5'd12: a = 38'sd13988227;
      5'd13: a = 38'sd6994114;
      5'd14: a = 38'sd3497057;
      5'd15: a = 38'sd1748528;
      5'd16: a = 38'sd874264;
      5'd17: a = 38'sd437132;
      5'd18: a = 38'sd218566;
      5'd19: a = 38'sd109283;
      5'd20: a = 38'sd54642;
      5'd21: a = 38'sd27321;
      5'd22: a = 38'sd13660;
      5'd23: a = 38'sd6830;
      5'd24: a = 38'sd3415;
      5'd25: a = 38'sd1708;
      5'd26: a = 38'sd854;
      5'd27: a = 38'sd427;
      5'd28: a = 38'sd213;
      5'd29: a = 38'sd107;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// ===== rtl/svap_sincos.sv =====
// Pipelined rotation CORDIC: millidegree angle in, Q30 cos and sin out.
module svap_sincos #(
  parameter int TagW = 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_vld,
  input  logic signed [20:0]     in_mdeg,
  input  logic [TagW-1:0]        in_tag,
  output logic                   out_vld,
  output logic signed [31:0]     out_cos,
  output logic signed [31:0]     out_sin,
  output logic [TagW-1:0]        out_tag
);
  import svap_pkg::*;

  logic [Steps:0]          vld_r;
  logic signed [33:0]      x_r [Steps+1];
  logic signed [33:0]      y_r [Steps+1];
  logic signed [38:0]      z_r [Steps+1];
  logic                    neg_r [Steps+1];
  logic [TagW-1:0]         tag_r [Steps+1];

  logic signed [20:0] a0, a1, a2;
  logic               neg0;

  // Reduce modulo 360 degrees toward zero, then fold into -90..90 degrees;
  // the result sign flips for the outer half.
  always_comb begin
    a0 = in_mdeg;
    if (in_mdeg >= 21'sd720000) a0 = in_mdeg - 21'sd720000;
    else if (in_mdeg >= 21'sd360000) a0 = in_mdeg - 21'sd360000;
    else if (in_mdeg <= -21'sd720000) a0 = in_mdeg + 21'sd720000;
    else if (in_mdeg <= -21'sd360000) a0 = in_mdeg + 21'sd360000;
    a1 = (a0 >= 21'sd180000) ? a0 - 21'sd360000 :
         (a0 < -21'sd180000) ? a0 + 21'sd360000 : a0;
    neg0 = 1'b0;
    a2 = a1;
    if (a1 > 21'sd90000) begin
      a2 = a1 - 21'sd180000;
      neg0 = 1'b1;
    end else if (a1 < -21'sd90000) begin
      a2 = a1 + 21'sd180000;
      neg0 = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else vld_r <= {vld_r[Steps-1:0], in_vld};
  end

  always_ff @(posedge clk) begin
    x_r[0]   <= 34'(InvGainQ30);
    y_r[0]   <= '0;
    z_r[0]   <= 39'(a2) * 39'(NdegPerMdeg);
    neg_r[0] <= neg0;
    tag_r[0] <= in_tag;
  end

  for (genvar i = 0; i < Steps; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (z_r[i] >= 0) begin
        x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] - 39'(atan_ndeg(5'(i)));
      end else begin
        x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] + 39'(atan_ndeg(5'(i)));
      end
      neg_r[i+1] <= neg_r[i];
      tag_r[i+1] <= tag_r[i];
    end
  end

  assign out_vld = vld_r[Steps];
  assign out_cos = neg_r[Steps] ? 32'(-x_r[Steps]) : 32'(x_r[Steps]);
  assign out_sin = neg_r[Steps] ? 32'(-y_r[Steps]) : 32'(y_r[Steps]);
  assign out_tag = tag_r[Steps];

endmodule

// ===== rtl/svap_divider.sv =====
// Pipelined restoring divider, one quotient bit per stage, rounded and saturated.
module svap_divider #(
  parameter int TagW = 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_vld,
  input  logic signed [74:0]  in_num,
  input  logic signed [47:0]  in_den,
  input  logic [TagW-1:0]     in_tag,
  output logic                out_vld,
  output logic signed [39:0]  out_quo,
  output logic [TagW-1:0]     out_tag
);
  import svap_pkg::*;

  localparam int NW = 76;
  localparam int DW = 48;

  logic [NW:0]          vld_r;
  logic [NW-1:0]        n_r [NW+1];
  logic [NW-1:0]        q_r [NW+1];
  logic [DW:0]          rem_r [NW+1];
  logic [DW-1:0]        d_r [NW+1];
  logic                 neg_r [NW+1];
  logic [TagW-1:0]      tag_r [NW+1];
  logic [NW-1:0]        un, ud_half;

  // Rounded: divide |n| + |d|/2 by |d|.
  always_comb begin
    un = (in_num < 0) ? NW'(-76'(in_num)) : NW'(in_num);
    ud_half = NW'(((in_den < 0) ? 48'(-in_den) : 48'(in_den)) >> 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else vld_r <= {vld_r[NW-1:0], in_vld};
  end

  always_ff @(posedge clk) begin
    n_r[0]   <= un + ud_half;
    d_r[0]   <= (in_den < 0) ? 48'(-in_den) : 48'(in_den);
    q_r[0]   <= '0;
    rem_r[0] <= '0;
    neg_r[0] <= (in_num < 0) != (in_den < 0);
    tag_r[0] <= in_tag;
  end

  for (genvar i = 0; i < NW; i++) begin : g_bit
    logic [DW:0] t;
    assign t = {rem_r[i][DW-1:0], n_r[i][NW-1-i]};
    always_ff @(posedge clk) begin
      if (t >= {1'b0, d_r[i]}) begin
        rem_r[i+1] <= t - {1'b0, d_r[i]};
        q_r[i+1]   <= q_r[i] | (NW'(1) << (NW-1-i));
      end else begin
        rem_r[i+1] <= t;
        q_r[i+1]   <= q_r[i];
      end
      n_r[i+1]   <= n_r[i];
      d_r[i+1]   <= d_r[i];
      neg_r[i+1] <= neg_r[i];
      tag_r[i+1] <= tag_r[i];
    end
  end

  logic [NW-1:0] qf;
  always_comb begin
    qf = q_r[NW];
    if (neg_r[NW]) begin
      if (qf > NW'(SatPos) + NW'(1)) qf = NW'(SatPos) + NW'(1);
      out_quo = 40'(-qf);
    end else begin
      if (qf > NW'(SatPos)) qf = NW'(SatPos);
      out_quo = 40'(qf);
    end
  end

  assign out_vld = vld_r[NW];
  assign out_tag = tag_r[NW];

endmodule

// ===== rtl/svap_atan2.sv =====
// Pipelined vectoring CORDIC: atan2 in millidegrees, rounded and clamped.
module svap_atan2 #(
  parameter int TagW = 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_vld,
  input  logic                in_zero,
  input  logic signed [47:0]  in_y,
  input  logic signed [47:0]  in_x,
  input  logic [TagW-1:0]     in_tag,
  output logic                out_vld,
  output logic signed [18:0]  out_mdeg,
  output logic [TagW-1:0]     out_tag
);
  import svap_pkg::*;

  localparam int VW = 72;

  logic [Steps+2:0]       vld_r;
  logic signed [VW-1:0]   x_r [Steps+1];
  logic signed [VW-1:0]   y_r [Steps+1];
  logic signed [40:0]     z_r [Steps+1];
  logic                   zero_r [Steps+1];
  logic [TagW-1:0]        tag_r [Steps+3];
  logic signed [40:0]     off0;
  logic signed [47:0]     xa, ya;

  always_comb begin
    off0 = '0;
    xa = in_x;
    ya = in_y;
    if (in_x < 0) begin
      off0 = (in_y >= 0) ? 41'sd180000000000 : -41'sd180000000000;
      xa = -in_x;
      ya = -in_y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else vld_r <= {vld_r[Steps+1:0], in_vld};
  end

  always_ff @(posedge clk) begin
    x_r[0]    <= VW'(xa) <<< 20;
    y_r[0]    <= VW'(ya) <<< 20;
    z_r[0]    <= off0;
    zero_r[0] <= in_zero || (in_x == 0 && in_y == 0);
    tag_r[0]  <= in_tag;
  end

  for (genvar i = 0; i < Steps; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (y_r[i] >= 0) begin
        x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] + 41'(atan_ndeg(5'(i)));
      end else begin
        x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] - 41'(atan_ndeg(5'(i)));
      end
      zero_r[i+1] <= zero_r[i];
      tag_r[i+1]  <= tag_r[i];
    end
  end

  // Round nanodegrees to millidegrees: reciprocal multiply, then one correction.
  logic [40:0]  mag;
  logic [40:0]  magh_r;
  logic         neg_r, zr_r, neg2_r, zr2_r;
  logic [21:0]  qe_r;
  logic [40:0]  magh2_r;
  logic [62:0]  prod;
  logic [21:0]  qest;
  logic [40:0]  rem;
  logic [21:0]  qfin;
  logic signed [22:0] r;

  always_comb mag = (z_r[Steps] < 0) ? 41'(-z_r[Steps]) : 41'(z_r[Steps]);

  always_ff @(posedge clk) begin
    magh_r <= mag + 41'd500000;
    neg_r  <= z_r[Steps] < 0;
    zr_r   <= zero_r[Steps];
    tag_r[Steps+1] <= tag_r[Steps];
  end

  // Estimate of m / 1e6 from the upper bits of m times floor(2^60 / 1e6); low by at most two.
  localparam logic [41:0] Recip = 42'd1152921504606;
  assign prod = 63'((84'(magh_r[40:20]) * 84'(Recip)) >> 40);
  assign qest = 22'(prod);

  always_ff @(posedge clk) begin
    qe_r    <= qest;
    magh2_r <= magh_r;
    neg2_r  <= neg_r;
    zr2_r   <= zr_r;
    tag_r[Steps+2] <= tag_r[Steps+1];
  end

  always_comb begin
    qfin = qe_r;
    rem = magh2_r - 41'(qe_r) * 41'd1000000;
    while_fix: begin
      if (rem >= 41'd1000000) qfin = qe_r + 22'd1;
      if (rem >= 41'd2000000) qfin = qe_r + 22'd2;
      if (rem >= 41'd3000000) qfin = qe_r + 22'd3;
    end
    r = neg2_r ? -23'(qfin) : 23'(qfin);
    if (r > 23'sd180000) r = 23'sd180000;
    if (r < -23'sd180000) r = -23'sd180000;
    if (zr2_r) r = '0;
  end

  assign out_vld  = vld_r[Steps+2];
  assign out_mdeg = 19'(r);
  assign out_tag  = tag_r[Steps+2];

endmodule

// ===== rtl/satellite_view_angle_projection.sv =====
// Top level of the satellite view angle projection pipeline.
//
// Usage: drive in_latitude_mdeg, in_longitude_mdeg and in_altitude_m with
// start high; busy is always low, so a transaction is accepted every cycle.
// One result per transaction appears on the out_ ports with out_valid high
// for one cycle, in input order. The path runs through the sin/cos CORDIC,
// stages A, B and C forming x, y, z and the sight line, then the divider in
// parallel with the atan2 CORDIC; the divider's one-bit-per-stage chain is
// the longer of the two. Throughput is one transaction per cycle. The cfg_
// port writes the planet radius, satellite radius and satellite longitude;
// cfg_ready is always high and writes are meant while the pipeline is
// empty. Synchronous reset empties the pipeline and restores register
// defaults. The receiver cannot stall: results are presented once and
// must be taken.
module satellite_view_angle_projection (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic signed [17:0]  in_latitude_mdeg,
  input  logic signed [18:0]  in_longitude_mdeg,
  input  logic [23:0]         in_altitude_m,
  output logic                out_valid,
  output logic signed [18:0]  out_alpha_mdeg,
  output logic signed [39:0]  out_proj_y_m,
  output logic signed [39:0]  out_proj_z_m,
  output logic                out_parallel_flag,
  output logic [18:0]         out_east_longitude_mdeg,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  import svap_pkg::*;

  logic [26:0]        planet_r;
  logic [29:0]        satr_r;
  logic signed [18:0] satlon_r;

  assign cfg_ready = 1'b1;
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      planet_r <= 27'd6371000;
      satr_r   <= 30'd42164000;
      satlon_r <= 19'sd140700;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PLANET_RADIUS: planet_r <= cfg_data[26:0];
        REG_SAT_RADIUS:    satr_r   <= cfg_data[29:0];
        REG_SAT_LONGITUDE: satlon_r <= cfg_data[18:0];
        default: ;
      endcase
    end
  end

  // Stage 0: angles, radius, east longitude.
  logic signed [20:0] th, ph0, ph;
  logic [27:0]        r0;
  logic [18:0]        east0;
  always_comb begin
    th  = 21'sd90000 - 21'(in_latitude_mdeg);
    ph0 = 21'(in_longitude_mdeg) - 21'(satlon_r);
    ph  = (ph0 < -21'sd180000) ? ph0 + 21'sd360000 : ph0;
    r0  = 28'(in_altitude_m) + 28'(planet_r);
    east0 = (in_longitude_mdeg > 0) ? 19'(in_longitude_mdeg)
                                    : 19'(20'sd360000 + 20'(in_longitude_mdeg));
  end

  localparam int TW = 28 + 19;
  logic [TW-1:0] tag_in, tag_a;
  assign tag_in = {r0, east0};

  logic               vt, vp;
  logic signed [31:0] ct, st, cp, sp;
  logic [TW-1:0]      tag_p;

  svap_sincos #(.TagW(TW)) u_th (
    .clk, .rst_n, .in_vld(start), .in_mdeg(th), .in_tag(tag_in),
    .out_vld(vt), .out_cos(ct), .out_sin(st), .out_tag(tag_a));
  svap_sincos #(.TagW(1)) u_ph (
    .clk, .rst_n, .in_vld(start), .in_mdeg(ph), .in_tag(1'b0),
    .out_vld(vp), .out_cos(cp), .out_sin(sp), .out_tag());
  assign tag_p = tag_a;

  // Stage A: unit-vector products rounded to Q30.
  logic [2:0]         v_r;
  logic signed [31:0] ux_r, uy_r, uz_r;
  logic [27:0]        ra_r;
  logic [18:0]        ea_r, eb_r, ec_r;
  logic signed [63:0] pxs, pys;
  assign pxs = 64'(st) * 64'(cp) + 64'sd536870912;
  assign pys = 64'(st) * 64'(sp) + 64'sd536870912;

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else v_r <= {v_r[1:0], vt};
  end

  always_ff @(posedge clk) begin
    ux_r <= 32'(pxs >>> 30);
    uy_r <= 32'(pys >>> 30);
    uz_r <= ct;
    ra_r <= tag_p[46:19];
    ea_r <= tag_p[18:0];
  end

  // Stage B: scale by radius into Q4 metres.
  logic signed [61:0] mx, my, mz;
  logic signed [33:0] dxb_r, dyb_r, dzb_r;
  assign mx = 62'(ux_r) * 62'($signed({1'b0, ra_r})) + 62'sd33554432;
  assign my = 62'(uy_r) * 62'($signed({1'b0, ra_r})) + 62'sd33554432;
  assign mz = 62'(uz_r) * 62'($signed({1'b0, ra_r})) + 62'sd33554432;
  always_ff @(posedge clk) begin
    dxb_r <= 34'(mx >>> 26);
    dyb_r <= 34'(my >>> 26);
    dzb_r <= 34'(mz >>> 26);
    eb_r  <= ea_r;
  end

  // Stage C: sight line and numerators.
  logic signed [47:0] dx_r, dy_r, dz_r;
  logic signed [74:0] ny_r, nz_r;
  logic               rs0_r;
  always_ff @(posedge clk) begin
    dx_r  <= 48'(dxb_r) - 48'($signed({1'b0, satr_r, 4'b0}));
    dy_r  <= 48'(dyb_r);
    dz_r  <= 48'(dzb_r);
    ny_r  <= -(75'(dyb_r) * 75'($signed({1'b0, satr_r})));
    nz_r  <= -(75'(dzb_r) * 75'($signed({1'b0, satr_r})));
    rs0_r <= satr_r == 0;
    ec_r  <= eb_r;
  end

  logic        flag_c;
  logic signed [47:0] aty, atx, dend;
  assign flag_c = dx_r == 0;
  assign aty  = (dx_r > 0) ? dy_r : -dy_r;
  assign atx  = (dx_r > 0) ? -dz_r : dz_r;
  assign dend = flag_c ? 48'sd1 : dx_r;

  logic               vy, va;
  logic signed [39:0] qy, qz;
  logic [19:0]        tag_y;
  logic signed [18:0] al;

  svap_divider #(.TagW(20)) u_dy (
    .clk, .rst_n, .in_vld(v_r[2]), .in_num(ny_r), .in_den(dend),
    .in_tag({flag_c, ec_r}), .out_vld(vy), .out_quo(qy), .out_tag(tag_y));
  svap_divider #(.TagW(1)) u_dz (
    .clk, .rst_n, .in_vld(v_r[2]), .in_num(nz_r), .in_den(dend),
    .in_tag(1'b0), .out_vld(), .out_quo(qz), .out_tag());
  svap_atan2 #(.TagW(1)) u_at (
    .clk, .rst_n, .in_vld(v_r[2]), .in_zero(flag_c || rs0_r),
    .in_y(aty), .in_x(atx), .in_tag(1'b0),
    .out_vld(va), .out_mdeg(al), .out_tag());

  // Align the shorter atan2 path with the divider.
  localparam int AD = 77 - 33;
  logic signed [18:0] ald_r [AD];
  always_ff @(posedge clk) begin
    ald_r[0] <= al;
    for (int k = 1; k < AD; k++) ald_r[k] <= ald_r[k-1];
  end

  assign out_valid = vy;
  assign out_parallel_flag = tag_y[19];
  assign out_east_longitude_mdeg = tag_y[18:0];
  assign out_proj_y_m = tag_y[19] ? '0 : qy;
  assign out_proj_z_m = tag_y[19] ? '0 : qz;
  assign out_alpha_mdeg = ald_r[AD-1];

  a_busy: assert property (@(posedge clk) busy == 1'b0) else $error("busy set");
  a_alpha_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_parallel_flag |-> out_alpha_mdeg == 0)
    else $error("alpha nonzero on parallel");
  a_va: assert property (@(posedge clk) disable iff (!rst_n)
    va |-> ##44 out_valid) else $error("atan2 path misaligned");
  a_cordic_sync: assert property (@(posedge clk) disable iff (!rst_n)
    vt == vp) else $error("sin/cos pipelines out of step");

endmodule
